FILE: rtl/core/oftc_pkg.sv
`default_nettype none

package oftc_pkg;

  // frequency request width in hertz
  localparam int unsigned FREQ_WIDTH = 27;

  localparam int unsigned BASE_HZ    = 1039;
  localparam int unsigned DAC_NUM    = 2078;
  localparam int unsigned DAC_OFFSET = 2048;
  localparam int unsigned DAC_MAX    = 1023;
  localparam int unsigned OCT_MAX    = 15;
  localparam int unsigned OCT_W      = 4;
  localparam int unsigned DAC_W      = 10;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned WORD_W     = 16;

  // quotient bits: top bit flags a quotient of 4096 or more
  localparam int unsigned QUO_W = 13;

  // numerator 2*N + f stays below 2^39 for any frequency width up to 32
  localparam int unsigned NUM_W = 39;

  // divisor 2*f shifted up by QUO_W-1 must fit next to the numerator
  localparam int unsigned CMP_W =
    (FREQ_WIDTH + QUO_W > NUM_W) ? FREQ_WIDTH + QUO_W : NUM_W;

  // smallest quotient that still gives a dac value within range
  localparam int unsigned QUO_LOW = DAC_OFFSET - DAC_MAX;

  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [CMP_W-1:0] dsor;
    logic [QUO_W-1:0] quo;
    logic [OCT_W-1:0] octave;
    logic             clamped;
  } oftc_div_t;

endpackage

`default_nettype wire

FILE: rtl/core/oscillator_freq_to_code_top.sv
`default_nettype none

// Frequency to oscillator control word. Each request carries a frequency in
// whole hertz; the block returns octave = floor(log2(f/1039)) clamped to
// 0..15, the ten-bit dac value 2048 - 2078*2^(10+octave)/f rounded to
// nearest (ties down) and clamped to 0..1023, the packed 16-bit word
// {octave, dac, output_mode} and a flag that is set when either value was
// saturated. A zero frequency gives octave 0, dac 0 and the flag set. The
// block takes one request every cycle while the output accepts results;
// each passes the front register (octave search and numerator), a row of
// 13 divider cells that each settle one quotient bit, and the output
// register. Backpressure on the output stalls the row; a stage that is
// empty keeps taking data. output_mode is written through cfg_we_i and
// applies to requests that reach the output register after the write.

module oscillator_freq_to_code_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [oftc_pkg::MODE_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [oftc_pkg::FREQ_WIDTH-1:0]  frequency_hz_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [oftc_pkg::WORD_W-1:0]      control_word_o,
  output logic [oftc_pkg::OCT_W-1:0]       octave_o,
  output logic [oftc_pkg::DAC_W-1:0]       dac_value_o,
  output logic                             clamped_o
);
  import oftc_pkg::*;

  oftc_div_t       stage_data [QUO_W+1];
  logic [QUO_W:0]  stage_valid;
  logic [QUO_W:0]  stage_ready;

  oftc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .frequency_hz_i (frequency_hz_i),
    .valid_o        (stage_valid[0]),
    .ready_i        (stage_ready[0]),
    .data_o         (stage_data[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    oftc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[i]),
      .ready_o (stage_ready[i]),
      .data_i  (stage_data[i]),
      .valid_o (stage_valid[i+1]),
      .ready_i (stage_ready[i+1]),
      .data_o  (stage_data[i+1])
    );
  end

  oftc_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_i        (stage_valid[QUO_W]),
    .ready_o        (stage_ready[QUO_W]),
    .data_i         (stage_data[QUO_W]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .control_word_o (control_word_o),
    .octave_o       (octave_o),
    .dac_value_o    (dac_value_o),
    .clamped_o      (clamped_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/oftc_front.sv
`default_nettype none

module oftc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [oftc_pkg::FREQ_WIDTH-1:0]  frequency_hz_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output oftc_pkg::oftc_div_t              data_o
);
  import oftc_pkg::*;

  logic                 valid_q;
  oftc_div_t            data_q, data_d;
  logic [NUM_W-1:0]     f_ext;
  logic [NUM_W-1:0]     two_n;
  logic [NUM_W-1:0]     num;
  logic [CMP_W-1:0]     dsor;
  logic [OCT_W-1:0]     oct;
  logic                 oct_clamp;

  assign f_ext = {{(NUM_W-FREQ_WIDTH){1'b0}}, frequency_hz_i};

  // largest k with base << k not above f
  always_comb begin
    oct = '0;
    for (int k = 1; k <= OCT_MAX; k++) begin
      if (f_ext >= (NUM_W'(BASE_HZ) << k)) begin
        oct = OCT_W'(k);
      end
    end
  end

  assign oct_clamp = (f_ext < NUM_W'(BASE_HZ)) ||
                     (f_ext >= (NUM_W'(BASE_HZ) << (OCT_MAX + 1)));

  // rounded quotient is floor((2N + f) / 2f)
  assign two_n = NUM_W'(DAC_NUM) << (5'd11 + 5'(oct));
  assign num   = two_n + f_ext;
  assign dsor  = {{(CMP_W-FREQ_WIDTH-1){1'b0}}, frequency_hz_i, 1'b0} << (QUO_W - 1);

  always_comb begin
    data_d.rem     = {{(CMP_W-NUM_W){1'b0}}, num};
    data_d.dsor    = dsor;
    data_d.quo     = '0;
    data_d.octave  = oct;
    data_d.clamped = oct_clamp;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/oftc_div_cell.sv
`default_nettype none

module oftc_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  oftc_pkg::oftc_div_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output oftc_pkg::oftc_div_t data_o
);
  import oftc_pkg::*;

  logic      valid_q;
  oftc_div_t data_q, data_d;
  logic      sub_ok;

  // one restoring step: try the divisor, then halve it for the next cell
  assign sub_ok = (data_i.rem >= data_i.dsor);

  always_comb begin
    data_d         = data_i;
    data_d.rem     = sub_ok ? (data_i.rem - data_i.dsor) : data_i.rem;
    data_d.dsor    = data_i.dsor >> 1;
    data_d.quo     = {data_i.quo[QUO_W-2:0], sub_ok};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/oftc_pack.sv
`default_nettype none

module oftc_pack (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [oftc_pkg::MODE_W-1:0]       cfg_wdata_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  oftc_pkg::oftc_div_t               data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [oftc_pkg::WORD_W-1:0]       control_word_o,
  output logic [oftc_pkg::OCT_W-1:0]        octave_o,
  output logic [oftc_pkg::DAC_W-1:0]        dac_value_o,
  output logic                              clamped_o
);
  import oftc_pkg::*;

  logic              valid_q;
  logic [MODE_W-1:0] mode_q;
  logic [WORD_W-1:0] word_q, word_d;
  logic [OCT_W-1:0]  oct_q;
  logic [DAC_W-1:0]  dac_q, dac_d;
  logic              clamp_q, clamp_d;
  logic [QUO_W-1:0]  quo;
  logic [QUO_W-1:0]  diff;

  assign quo  = data_i.quo;
  assign diff = QUO_W'(DAC_OFFSET) - quo;

  // dac = 2048 - quotient, saturated to the ten-bit range
  always_comb begin
    dac_d   = diff[DAC_W-1:0];
    clamp_d = data_i.clamped;
    if (quo[QUO_W-1] || (quo > QUO_W'(DAC_OFFSET))) begin
      dac_d   = '0;
      clamp_d = 1'b1;
    end else if (quo < QUO_W'(QUO_LOW)) begin
      dac_d   = DAC_W'(DAC_MAX);
      clamp_d = 1'b1;
    end
  end

  assign word_d = {data_i.octave, dac_d, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q  <= word_d;
      oct_q   <= data_i.octave;
      dac_q   <= dac_d;
      clamp_q <= clamp_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign control_word_o = word_q;
  assign octave_o       = oct_q;
  assign dac_value_o    = dac_q;
  assign clamped_o      = clamp_q;

endmodule

`default_nettype wire

FILE: dv/oscillator_freq_to_code_top_tb.sv
`default_nettype none

module oscillator_freq_to_code_top_tb;

  import oftc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam longint      FREQ_TOP    = (longint'(1) << FREQ_WIDTH) - 1;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [OCT_W-1:0]  octave;
    logic [DAC_W-1:0]  dac;
    logic              clamped;
  } osc_code_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [MODE_W-1:0]     cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [FREQ_WIDTH-1:0] frequency_hz_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [WORD_W-1:0]     control_word_o;
  logic [OCT_W-1:0]      octave_o;
  logic [DAC_W-1:0]      dac_value_o;
  logic                  clamped_o;

  osc_code_t         pending_codes[$];
  logic [MODE_W-1:0] mode_shadow = '0;
  bit                idle_on = 1'b0;
  int unsigned       hold_req_cnt = 0;
  int unsigned       hold_seen = 0;
  int unsigned       hold_left = 0;
  int unsigned       stall_left = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       err_cnt = 0;
  int unsigned       req_cnt = 0;
  int unsigned       code_cnt = 0;
  int unsigned       clamp_cnt = 0;
  int unsigned       mode_writes = 0;

  oscillator_freq_to_code_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frequency_hz_i (frequency_hz_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .control_word_o (control_word_o),
    .octave_o       (octave_o),
    .dac_value_o    (dac_value_o),
    .clamped_o      (clamped_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic osc_code_t freq_to_code(logic [FREQ_WIDTH-1:0] freq,
                                             logic [MODE_W-1:0] mode);
    osc_code_t res;
    longint    f;
    longint    num;
    longint    den;
    longint    dac;
    int        oct;
    bit        sat;
    f   = longint'(freq);
    oct = 0;
    sat = 1'b0;
    if (f < longint'(BASE_HZ)) sat = 1'b1;
    while (oct < int'(OCT_MAX) && (longint'(BASE_HZ) << (oct + 1)) <= f) oct++;
    if ((longint'(BASE_HZ) << (OCT_MAX + 1)) <= f) sat = 1'b1;
    if (f == 0) begin
      dac = 0;
      sat = 1'b1;
    end else begin
      // round half down: ceil((2*(2048 f - N) - f) / 2f)
      num = 2 * (longint'(DAC_OFFSET) * f - (longint'(DAC_NUM) << (10 + oct))) - f;
      den = 2 * f;
      if (num >= 0) dac = (num + den - 1) / den;
      else dac = -((-num) / den);
      if (dac > longint'(DAC_MAX)) begin
        dac = DAC_MAX;
        sat = 1'b1;
      end else if (dac < 0) begin
        dac = 0;
        sat = 1'b1;
      end
    end
    res.octave  = oct[OCT_W-1:0];
    res.dac     = dac[DAC_W-1:0];
    res.clamped = sat;
    res.word    = {res.octave, res.dac, mode};
    return res;
  endfunction

  function automatic logic [FREQ_WIDTH-1:0] pick_freq();
    longint f;
    longint lo;
    longint hi;
    int     k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // one octave band, below-range band included
        k = $urandom_range(0, 17);
        if (k == 0) begin
          lo = 0;
          hi = BASE_HZ - 1;
        end else begin
          lo = longint'(BASE_HZ) << (k - 1);
          hi = (longint'(BASE_HZ) << k) - 1;
        end
        if (hi > FREQ_TOP) hi = FREQ_TOP;
        f = lo + longint'($urandom_range(0, 32'(hi - lo)));
      end
      4, 5: f = longint'($urandom()) & FREQ_TOP;
      6, 7: begin
        k = $urandom_range(0, 16);
        f = (longint'(BASE_HZ) << k) + longint'($urandom_range(0, 6)) - 3;
      end
      8: begin
        // just under the next octave, where the dac saturates high
        k = $urandom_range(0, 15);
        f = (longint'(DAC_NUM) << k) - longint'($urandom_range(1, 4));
      end
      default: f = longint'($urandom_range(0, 2100));
    endcase
    if (f < 0) f = 0;
    if (f > FREQ_TOP) f = FREQ_TOP;
    return f[FREQ_WIDTH-1:0];
  endfunction

  // sender: called at a falling edge, returns at a falling edge
  task automatic send_freq(logic [FREQ_WIDTH-1:0] freq);
    in_valid_i     = 1'b1;
    frequency_hz_i = freq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_codes.push_back(freq_to_code(freq, mode_shadow));
    req_cnt++;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i     = 1'b0;
      frequency_hz_i = FREQ_WIDTH'($urandom());
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  task automatic drain_block();
    in_valid_i = 1'b0;
    while (pending_codes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] mode);
    drain_block();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = MODE_W'($urandom());
    mode_shadow = mode;
    mode_writes++;
  endtask

  // receiver: random stall bursts while idle_on is set, plus a long hold-off when a test requests one
  always @(negedge clk_i) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i = 1'b0;
      stall_left  = $urandom_range(1, 3) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    osc_code_t exp_code;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_codes.size() == 0) begin
        $error("result with no request outstanding: word %h", control_word_o);
        err_cnt++;
      end else begin
        exp_code = pending_codes.pop_front();
        code_cnt++;
        if (exp_code.clamped) clamp_cnt++;
        if (control_word_o !== exp_code.word) begin
          $error("control_word expected %h actual %h", exp_code.word, control_word_o);
          err_cnt++;
        end
        if (octave_o !== exp_code.octave) begin
          $error("octave expected %0d actual %0d", exp_code.octave, octave_o);
          err_cnt++;
        end
        if (dac_value_o !== exp_code.dac) begin
          $error("dac_value expected %0d actual %0d", exp_code.dac, dac_value_o);
          err_cnt++;
        end
        if (clamped_o !== exp_code.clamped) begin
          $error("clamped expected %0d actual %0d", exp_code.clamped, clamped_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL oscillator_freq_to_code_top");
      $finish;
    end
  end

  // boundaries of the octave search and the dac range, run under the reset mode
  task automatic test_edge_frequencies();
    longint edges[$];
    edges = '{0, 1, 2, 1000, 1038, 1039, 1040, 2077, 2078, 2079, 4095, 4096, 4155,
              4156, 4157, 1039 * 256, 2078 * 256 - 1, (1039 << 15) - 1, 1039 << 15,
              (1039 << 16) - 1, 1039 << 16, (1039 << 16) + 1, 27'h5555555,
              27'h2AAAAAA, FREQ_TOP};
    idle_on = 1'b1;
    foreach (edges[i]) send_freq(edges[i][FREQ_WIDTH-1:0]);
    drain_block();
  endtask

  task automatic test_output_modes();
    logic [MODE_W-1:0] modes[4];
    modes = '{2'd3, 2'd1, 2'd2, 2'd0};
    foreach (modes[i]) begin
      write_mode(modes[i]);
      repeat (8) send_freq(pick_freq());
    end
    drain_block();
  endtask

  task automatic test_random_mix();
    write_mode(2'd2);
    idle_on = 1'b1;
    repeat (1250) send_freq(pick_freq());
    drain_block();
  endtask

  // output held off long enough that the pipe fills and the input stalls
  task automatic test_output_hold();
    write_mode(2'd1);
    idle_on = 1'b0;
    hold_req_cnt++;
    repeat (80) send_freq(pick_freq());
    drain_block();
  endtask

  task automatic test_streaming();
    write_mode(2'd3);
    idle_on = 1'b0;
    repeat (60) send_freq(pick_freq());
    drain_block();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    frequency_hz_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_edge_frequencies();
    test_output_modes();
    test_random_mix();
    test_output_hold();
    test_streaming();

    if (pending_codes.size() != 0) begin
      $error("%0d results never arrived", pending_codes.size());
      err_cnt++;
    end
    $display("sent %0d frequency requests, checked %0d codes (%0d saturated)",
             req_cnt, code_cnt, clamp_cnt);
    $display("%0d output mode writes, one long output hold, %0d mismatches",
             mode_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS oscillator_freq_to_code_top");
    end else begin
      $display("FAIL oscillator_freq_to_code_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/oftc_pkg.sv
rtl/core/oftc_front.sv
rtl/core/oftc_div_cell.sv
rtl/core/oftc_pack.sv
rtl/core/oscillator_freq_to_code_top.sv
dv/oscillator_freq_to_code_top_tb.sv
